// ===== hw/rtl/lcs_pkg.sv =====
package lcs_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam int FRAME_WIDTH_RESET  = 400;
  localparam int FRAME_HEIGHT_RESET = 300;

  localparam int DEFAULT_MAX_WIDTH  = 512;
  localparam int DEFAULT_MAX_HEIGHT = 512;

  // Result fields
  localparam int COORD_W = 9;

  // Life rule
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  localparam int QUEUE_DEPTH = 2;

  // Which neighbours of the described cell lie inside the frame
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } mask_t;

  // One stream step handed from the front to the back
  typedef struct packed {
    logic               alive;      // value stored into the line stores
    logic               first;      // first step of a frame: ring address restarts
    logic               addr_last;  // ring address of this step is the last of the row
    logic               has_out;    // this step yields a result
    mask_t              mask;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               frame_end;
  } entry_t;

endpackage

// ===== hw/rtl/life_cell_stencil_top.sv =====
// Throughput: one item per cycle, sustained while the result side takes one per cycle.
// With the queue empty, an item's result passes through the two-entry queue and then the
// output register before it is offered; it describes the cell one row plus one cell
// behind that item.
// Reset: stream position clears, sizes return to 400 x 300 (clamped to the maximum),
// the queue and output register empty. Line stores are not cleared; edge masks hide them.
module life_cell_stencil_top #(
  parameter int MaxWidth  = lcs_pkg::DEFAULT_MAX_WIDTH,
  parameter int MaxHeight = lcs_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic                             cell_alive_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             next_alive_o,
  output logic [lcs_pkg::COORD_W-1:0]      out_column_o,
  output logic [lcs_pkg::COORD_W-1:0]      out_row_o,
  output logic                             frame_end_o,
  input  logic                             cfg_we_i,
  input  logic [lcs_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [lcs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  lcs_pkg::entry_t push_entry;
  lcs_pkg::entry_t head_entry;

  lcs_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .cell_alive_i (cell_alive_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .entry_o      (push_entry)
  );

  lcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_entry)
  );

  lcs_back #(
    .MaxWidth (MaxWidth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .entry_i      (head_entry),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .next_alive_o (next_alive_o),
    .out_column_o (out_column_o),
    .out_row_o    (out_row_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

// ===== hw/rtl/lcs_front.sv =====
module lcs_front #(
  parameter int MaxWidth  = lcs_pkg::DEFAULT_MAX_WIDTH,
  parameter int MaxHeight = lcs_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic                             cell_alive_i,
  input  logic                             cfg_we_i,
  input  logic [lcs_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [lcs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             q_full_i,
  output logic                             push_o,
  output lcs_pkg::entry_t                  entry_o
);

  localparam int ColW = $clog2(MaxWidth + 1);
  localparam int RowW = $clog2(MaxHeight + 1);
  localparam int WidthReset  = (lcs_pkg::FRAME_WIDTH_RESET > MaxWidth) ?
                               MaxWidth : lcs_pkg::FRAME_WIDTH_RESET;
  localparam int HeightReset = (lcs_pkg::FRAME_HEIGHT_RESET > MaxHeight) ?
                               MaxHeight : lcs_pkg::FRAME_HEIGHT_RESET;

  logic [ColW-1:0] width_q, width_d;
  logic [RowW-1:0] height_q, height_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            started_q, started_d;

  logic            accept;
  logic            ignored;
  logic            step;
  logic            in_frame;
  logic            col_is_w;
  logic            col_zero;
  logic [ColW-1:0] width_m1;
  logic [RowW-1:0] height_m1;
  logic [ColW-1:0] qc;
  logic [RowW-1:0] qr;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  // a drain item with no frame under way is dropped
  assign ignored    = ~started_q & op_i;
  assign step       = accept & ~ignored;
  assign push_o     = step;

  assign in_frame  = row_q < height_q;
  assign col_is_w  = col_q == width_q;
  assign col_zero  = col_q == '0;
  assign width_m1  = width_q - ColW'(1);
  assign height_m1 = height_q - RowW'(1);

  // described cell sits one row and one cell behind the stream position
  assign qc = col_zero ? width_m1 : col_q - ColW'(1);
  assign qr = col_zero ? row_q - RowW'(2) : row_q - RowW'(1);

  always_comb begin
    entry_o.alive       = ~op_i & in_frame & cell_alive_i;
    entry_o.first       = (row_q == '0) & col_zero;
    entry_o.addr_last   = col_is_w ? (width_q == ColW'(1)) : (col_q == width_m1);
    entry_o.has_out     = (row_q >= RowW'(2)) | ((row_q == RowW'(1)) & ~col_zero);
    entry_o.mask.top    = qr != '0;
    entry_o.mask.bottom = qr != height_m1;
    entry_o.mask.left   = qc != '0;
    entry_o.mask.right  = qc != width_m1;
    entry_o.column      = lcs_pkg::COORD_W'(qc);
    entry_o.row         = lcs_pkg::COORD_W'(qr);
    entry_o.frame_end   = (qr == height_m1) & (qc == width_m1);
  end

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    col_d     = col_q;
    row_d     = row_q;
    started_d = started_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        lcs_pkg::REG_FRAME_WIDTH: begin
          if (cfg_data_i == '0) begin
            width_d = ColW'(1);
          end else if (int'(cfg_data_i) > MaxWidth) begin
            width_d = ColW'(MaxWidth);
          end else begin
            width_d = ColW'(cfg_data_i);
          end
        end
        lcs_pkg::REG_FRAME_HEIGHT: begin
          if (cfg_data_i == '0) begin
            height_d = RowW'(1);
          end else if (int'(cfg_data_i) > MaxHeight) begin
            height_d = RowW'(MaxHeight);
          end else begin
            height_d = RowW'(cfg_data_i);
          end
        end
        default: begin
          width_d = width_q;
        end
      endcase
      col_d     = '0;
      row_d     = '0;
      started_d = 1'b0;
    end else if (step) begin
      started_d = 1'b1;
      if ((row_q == height_q) & col_is_w) begin
        // last drain item: restart the stream
        col_d     = '0;
        row_d     = '0;
        started_d = 1'b0;
      end else if ((col_q + ColW'(1) == width_q) & in_frame) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= ColW'(WidthReset);
      height_q  <= RowW'(HeightReset);
      col_q     <= '0;
      row_q     <= '0;
      started_q <= 1'b0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      col_q     <= col_d;
      row_q     <= row_d;
      started_q <= started_d;
    end
  end

endmodule

// ===== hw/rtl/lcs_queue.sv =====
module lcs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lcs_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output lcs_pkg::entry_t head_o
);

  localparam int Depth = lcs_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  lcs_pkg::entry_t slots_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i & ~pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i & ~push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/lcs_line_buf.sv =====
module lcs_line_buf #(
  parameter int MaxWidth = lcs_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        step_i,
  input  logic [$clog2(MaxWidth)-1:0] addr_i,
  input  logic [$clog2(MaxWidth)-1:0] addr_next_i,
  input  logic                        din_i,
  output logic                        dout_o
);

  logic mem [MaxWidth];
  logic rd_q;

  // Fetch the entry the next step overwrites, so the output is the input
  // one row of steps ago. On a one-cell row that entry is the one written now.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      mem[addr_i] <= din_i;
      if (addr_next_i == addr_i) begin
        rd_q <= din_i;
      end else begin
        rd_q <= mem[addr_next_i];
      end
    end
  end

  assign dout_o = rd_q;

endmodule

// ===== hw/rtl/lcs_back.sv =====
module lcs_back #(
  parameter int MaxWidth = lcs_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  lcs_pkg::entry_t              entry_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         next_alive_o,
  output logic [lcs_pkg::COORD_W-1:0]  out_column_o,
  output logic [lcs_pkg::COORD_W-1:0]  out_row_o,
  output logic                         frame_end_o
);

  localparam int AddrW = $clog2(MaxWidth);

  logic [AddrW-1:0] addr_q;
  logic [AddrW-1:0] addr_cur;
  logic [AddrW-1:0] addr_nxt;
  logic             pop;

  logic             lb1_out;
  logic             lb2_out;
  logic             t1_q, t2_q;
  logic             l1d1_q, l1d2_q;
  logic             l2d1_q, l2d2_q;

  logic [3:0]       count;
  logic             next_alive;

  logic                        out_valid_q, out_valid_d;
  logic                        next_alive_q;
  logic [lcs_pkg::COORD_W-1:0] column_q;
  logic [lcs_pkg::COORD_W-1:0] row_q;
  logic                        frame_end_q;

  assign pop   = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign pop_o = pop;

  assign addr_cur = entry_i.first ? '0 : addr_q;
  assign addr_nxt = entry_i.addr_last ? '0 : addr_cur + AddrW'(1);

  lcs_line_buf #(
    .MaxWidth (MaxWidth)
  ) u_line_prev (
    .clk_i       (clk_i),
    .step_i      (pop),
    .addr_i      (addr_cur),
    .addr_next_i (addr_nxt),
    .din_i       (entry_i.alive),
    .dout_o      (lb1_out)
  );

  lcs_line_buf #(
    .MaxWidth (MaxWidth)
  ) u_line_prev2 (
    .clk_i       (clk_i),
    .step_i      (pop),
    .addr_i      (addr_cur),
    .addr_next_i (addr_nxt),
    .din_i       (lb1_out),
    .dout_o      (lb2_out)
  );

  // Window taps: newest row (current, t1, t2), middle row (lb1, l1d1, l1d2),
  // oldest row (lb2, l2d1, l2d2); the centre cell is l1d1.
  always_comb begin
    count = {3'b0, entry_i.alive & entry_i.mask.bottom & entry_i.mask.right}
          + {3'b0, t1_q & entry_i.mask.bottom}
          + {3'b0, t2_q & entry_i.mask.bottom & entry_i.mask.left}
          + {3'b0, lb1_out & entry_i.mask.right}
          + {3'b0, l1d2_q & entry_i.mask.left}
          + {3'b0, lb2_out & entry_i.mask.top & entry_i.mask.right}
          + {3'b0, l2d1_q & entry_i.mask.top}
          + {3'b0, l2d2_q & entry_i.mask.top & entry_i.mask.left};
    if (count == lcs_pkg::BIRTH_COUNT) begin
      next_alive = 1'b1;
    end else if (count == lcs_pkg::KEEP_COUNT) begin
      next_alive = l1d1_q;
    end else begin
      next_alive = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q & ~out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop) begin
      out_valid_d = entry_i.has_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        addr_q <= addr_nxt;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      t1_q   <= entry_i.alive;
      t2_q   <= t1_q;
      l1d1_q <= lb1_out;
      l1d2_q <= l1d1_q;
      l2d1_q <= lb2_out;
      l2d2_q <= l2d1_q;
      if (entry_i.has_out) begin
        next_alive_q <= next_alive;
        column_q     <= entry_i.column;
        row_q        <= entry_i.row;
        frame_end_q  <= entry_i.frame_end;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_alive_o = next_alive_q;
  assign out_column_o = column_q;
  assign out_row_o    = row_q;
  assign frame_end_o  = frame_end_q;

endmodule
